FILE: src/cc20_pkg.sv
// Shared types, constants and block-function helpers of the ChaCha20 stream cipher.
// No dependencies; the design files other than the two interfaces refer to it by scope.
`default_nettype none
package cc20_pkg;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int POS_W   = 6;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(63);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [15:0][31:0] t_words;
    typedef logic [63:0][7:0]  t_bytes;

    typedef enum logic [2:0] {
        REG_KEY_0     = 3'd0,
        REG_KEY_1     = 3'd1,
        REG_KEY_2     = 3'd2,
        REG_KEY_3     = 3'd3,
        REG_NONCE_LO  = 3'd4,
        REG_NONCE_HI  = 3'd5,
        REG_INIT_CTR  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_message;
    } t_item;

    typedef struct packed {
        logic        go;
        logic        kill;
        logic [31:0] ctr;
    } t_core_ctl;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] tag;
    } t_core_sts;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_quad;

    function automatic t_words init_words(input logic [255:0] key, input logic [31:0] ctr,
                                          input logic [95:0] nonce);
        t_words w;
        w[0] = SIGMA_0;
        w[1] = SIGMA_1;
        w[2] = SIGMA_2;
        w[3] = SIGMA_3;
        for (int k = 0; k < 8; k++) begin
            w[4+k] = key[32*k +: 32];
        end
        w[12] = ctr;
        w[13] = nonce[31:0];
        w[14] = nonce[63:32];
        w[15] = nonce[95:64];
        return w;
    endfunction

    // half of a quarter round: rotations 16/12 in the first half, 8/7 in the second
    function automatic t_quad qhalf(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [31:0] d,
                                    input logic second);
        t_quad q;
        logic [31:0] x;
        logic [31:0] y;
        q.a = a + b;
        x   = d ^ q.a;
        q.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        q.c = c + q.d;
        y   = b ^ q.c;
        q.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
        return q;
    endfunction

endpackage
`default_nettype wire

FILE: src/cc20_in_if.sv
// Input channel of the stream cipher: one data byte and a message-start flag per transfer.
// Uses no package.
`default_nettype none
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_message;

    modport source (output valid, output data_byte, output start_message, input ready);
    modport sink   (input valid, input data_byte, input start_message, output ready);
endinterface
`default_nettype wire

FILE: src/cc20_out_if.sv
// Output channel of the stream cipher: one combined byte per transfer.
// Uses no package.
`default_nettype none
interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

FILE: src/cc20_regs.sv
// APB configuration registers: key, nonce and initial block counter.
// Depends on cc20_pkg for the register index codes and port widths.
`default_nettype none
module cc20_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cc20_pkg::ADDR_W-1:0] paddr,
    input  wire logic [cc20_pkg::DATA_W-1:0] pwdata,
    output logic      [cc20_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [255:0]                o_key,
    output logic      [95:0]                 o_nonce,
    output logic      [31:0]                 o_init_ctr,
    output logic                             o_wr
);
    logic [63:0] r_key_0, r_key_1, r_key_2, r_key_3, r_nonce_lo;
    logic [31:0] r_nonce_hi, r_init_ctr;
    logic        wr;
    cc20_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = cc20_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_0    <= '0;
            r_key_1    <= '0;
            r_key_2    <= '0;
            r_key_3    <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_init_ctr <= '0;
        end else if (wr) begin
            unique case (idx)
                cc20_pkg::REG_KEY_0:    r_key_0    <= pwdata;
                cc20_pkg::REG_KEY_1:    r_key_1    <= pwdata;
                cc20_pkg::REG_KEY_2:    r_key_2    <= pwdata;
                cc20_pkg::REG_KEY_3:    r_key_3    <= pwdata;
                cc20_pkg::REG_NONCE_LO: r_nonce_lo <= pwdata;
                cc20_pkg::REG_NONCE_HI: r_nonce_hi <= pwdata[31:0];
                cc20_pkg::REG_INIT_CTR: r_init_ctr <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            cc20_pkg::REG_KEY_0:    prdata = r_key_0;
            cc20_pkg::REG_KEY_1:    prdata = r_key_1;
            cc20_pkg::REG_KEY_2:    prdata = r_key_2;
            cc20_pkg::REG_KEY_3:    prdata = r_key_3;
            cc20_pkg::REG_NONCE_LO: prdata = r_nonce_lo;
            cc20_pkg::REG_NONCE_HI: prdata = {32'd0, r_nonce_hi};
            cc20_pkg::REG_INIT_CTR: prdata = {32'd0, r_init_ctr};
            default:                prdata = '0;
        endcase
    end

    assign o_key      = {r_key_3, r_key_2, r_key_1, r_key_0};
    assign o_nonce    = {r_nonce_hi, r_nonce_lo};
    assign o_init_ctr = r_init_ctr;
    assign o_wr       = wr;
endmodule
`default_nettype wire

FILE: src/cc20_front.sv
// Front end: accepts input transfers into a short queue and presents the head item.
// Depends on cc20_pkg (item type, queue sizing) and cc20_in_if.
`default_nettype none
module cc20_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    cc20_in_if.sink              i_in,
    output logic                 o_head_vld,
    output cc20_pkg::t_item      o_head,
    input  wire logic            i_pop
);
    cc20_pkg::t_item                r_q [cc20_pkg::Q_DEPTH];
    logic [cc20_pkg::Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [cc20_pkg::Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [cc20_pkg::Q_CNT_W-1:0]  r_cnt, n_cnt;
    logic                           push;

    assign i_in.ready = (r_cnt != cc20_pkg::Q_CNT_W'(cc20_pkg::Q_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? cc20_pkg::Q_PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop ? cc20_pkg::Q_PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_cnt    = cc20_pkg::Q_CNT_W'(r_cnt + cc20_pkg::Q_CNT_W'(push)
                                      - cc20_pkg::Q_CNT_W'(i_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{data_byte: i_in.data_byte, start_message: i_in.start_message};
        end
    end
endmodule
`default_nettype wire

FILE: src/cc20_core.sv
// Keystream block generator: four quarter-round lanes, half a quarter round per cycle,
// then the feed-forward add. Depends on cc20_pkg for the block types and round helpers.
`default_nettype none
module cc20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cc20_pkg::t_core_ctl i_ctl,
    input  wire logic [255:0]        i_key,
    input  wire logic [95:0]         i_nonce,
    output cc20_pkg::t_core_sts      o_sts,
    output cc20_pkg::t_words         o_block
);
    localparam int STEP_W = $clog2(4 * DOUBLE_ROUNDS + 2);
    localparam logic [STEP_W-1:0] STEP_FF  = STEP_W'(4 * DOUBLE_ROUNDS);
    localparam logic [STEP_W-1:0] STEP_FIN = STEP_W'(4 * DOUBLE_ROUNDS + 1);

    logic                 r_busy, n_busy;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [31:0]          r_tag;
    cc20_pkg::t_words     r_w, n_w;
    cc20_pkg::t_words     ini, ffw;
    wire cc20_pkg::t_words rnd;
    cc20_pkg::t_quad      res [4];
    logic                 diag, second;

    assign diag   = r_step[1];
    assign second = r_step[0];
    assign ini    = cc20_pkg::init_words(i_key, i_ctl.go ? i_ctl.ctr : r_tag, i_nonce);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        localparam int BC = 4 + g;
        localparam int CC = 8 + g;
        localparam int DC = 12 + g;
        localparam int BD = 4 + ((g + 1) % 4);
        localparam int CD = 8 + ((g + 2) % 4);
        localparam int DD = 12 + ((g + 3) % 4);

        assign res[g] = cc20_pkg::qhalf(r_w[g],
                                        diag ? r_w[BD] : r_w[BC],
                                        diag ? r_w[CD] : r_w[CC],
                                        diag ? r_w[DD] : r_w[DC],
                                        second);
        assign rnd[g]      = res[g].a;
        assign rnd[4 + g]  = diag ? res[(g + 3) % 4].b : res[g].b;
        assign rnd[8 + g]  = diag ? res[(g + 2) % 4].c : res[g].c;
        assign rnd[12 + g] = diag ? res[(g + 1) % 4].d : res[g].d;
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            ffw[k] = r_w[k] + ini[k];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_w    = r_w;
        priority if (i_ctl.kill) begin
            n_busy = 1'b0;
        end else if (i_ctl.go) begin
            n_busy = 1'b1;
            n_step = '0;
            n_w    = ini;
        end else if (r_busy) begin
            priority if (r_step == STEP_FIN) begin
                n_busy = 1'b0;
            end else if (r_step == STEP_FF) begin
                n_w    = ffw;
                n_step = STEP_W'(r_step + 1'b1);
            end else begin
                n_w    = rnd;
                n_step = STEP_W'(r_step + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (i_ctl.go) begin
            r_tag <= i_ctl.ctr;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && (r_step == STEP_FIN);
    assign o_sts.tag  = r_tag;
    assign o_block    = r_w;
endmodule
`default_nettype wire

FILE: src/cc20_back.sv
// Back end: tracks counter and byte position, steers block prefetch, and XORs the
// head item with the keystream. Depends on cc20_pkg and cc20_out_if.
`default_nettype none
module cc20_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_head_vld,
    input  wire cc20_pkg::t_item     i_head,
    output logic                     o_pop,
    cc20_out_if.source               o_out,
    input  wire logic                i_cfg_wr,
    input  wire logic [31:0]         i_init_ctr,
    output cc20_pkg::t_core_ctl      o_core_ctl,
    input  wire cc20_pkg::t_core_sts i_core_sts,
    input  wire cc20_pkg::t_words    i_block
);
    logic [31:0]                 r_ctr, n_ctr;
    logic [cc20_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_cur_vld, n_cur_vld;
    logic                        r_nxt_vld, n_nxt_vld;
    logic                        r_out_vld, n_out_vld;
    logic [31:0]                 r_nxt_tag;
    logic [7:0]                  r_out_byte;
    cc20_pkg::t_words            r_cur, r_nxt;
    cc20_pkg::t_bytes            cur_bytes, nxt_bytes;
    logic [31:0]                 want;
    logic                        nxt_hit, core_hit, nxt_load;
    logic                        use_cur, out_free, take;
    logic [7:0]                  ks_byte;

    assign want     = (i_head_vld && i_head.start_message) ? i_init_ctr
                    : (r_cur_vld ? 32'(r_ctr + 32'd1) : r_ctr);
    assign nxt_hit  = r_nxt_vld && (r_nxt_tag == want);
    assign core_hit = i_core_sts.busy && (i_core_sts.tag == want);
    assign nxt_load = i_core_sts.done && (i_core_sts.tag == want) && !i_cfg_wr;

    assign o_core_ctl.go   = !nxt_hit && !core_hit && !i_cfg_wr;
    assign o_core_ctl.kill = i_cfg_wr || (i_core_sts.busy && !core_hit && nxt_hit);
    assign o_core_ctl.ctr  = want;

    assign cur_bytes = cc20_pkg::t_bytes'(r_cur);
    assign nxt_bytes = cc20_pkg::t_bytes'(r_nxt);
    assign use_cur   = r_cur_vld && !i_head.start_message;
    assign out_free  = !r_out_vld || o_out.ready;
    assign take      = i_head_vld && out_free && (use_cur || nxt_hit);
    assign ks_byte   = use_cur ? cur_bytes[r_pos] : nxt_bytes[0];
    assign o_pop     = take;

    always_comb begin
        n_ctr     = r_ctr;
        n_pos     = r_pos;
        n_cur_vld = r_cur_vld;
        n_out_vld = r_out_vld;
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end
        if (take) begin
            n_out_vld = 1'b1;
            if (use_cur) begin
                if (r_pos == cc20_pkg::POS_LAST) begin
                    n_pos     = '0;
                    n_ctr     = 32'(r_ctr + 32'd1);
                    n_cur_vld = 1'b0;
                end else begin
                    n_pos = cc20_pkg::POS_W'(r_pos + 1'b1);
                end
            end else begin
                n_cur_vld = 1'b1;
                n_pos     = cc20_pkg::POS_W'(1);
                n_ctr     = want;
            end
        end
        priority if (i_cfg_wr) begin
            n_nxt_vld = 1'b0;
        end else if (nxt_load) begin
            n_nxt_vld = 1'b1;
        end else if (take && !use_cur) begin
            n_nxt_vld = 1'b0;
        end else begin
            n_nxt_vld = r_nxt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr     <= '0;
            r_pos     <= '0;
            r_cur_vld <= 1'b0;
            r_nxt_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ctr     <= n_ctr;
            r_pos     <= n_pos;
            r_cur_vld <= n_cur_vld;
            r_nxt_vld <= n_nxt_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_byte <= i_head.data_byte ^ ks_byte;
        end
        if (take && !use_cur) begin
            r_cur <= r_nxt;
        end
        if (nxt_load) begin
            r_nxt     <= i_block;
            r_nxt_tag <= i_core_sts.tag;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.out_byte = r_out_byte;
endmodule
`default_nettype wire

FILE: src/chacha20_stream_cipher.sv
// Top level of the ChaCha20 stream cipher: register port, front queue, back end, generator.
// Depends on cc20_pkg, cc20_in_if, cc20_out_if, cc20_regs, cc20_front, cc20_core, cc20_back.
//
// Usage: each transfer on i_in carries one data byte and a start_message flag; each
// transfer on o_out returns that byte XORed with the next keystream byte, in order.
// start_message reloads the block counter from initial_counter and restarts at byte 0.
// From input transfer to output transfer a byte passes the input queue and then the output
// register while keystream is on hand. Throughput is one byte per cycle while the receiver
// is ready and keystream is on hand: the generator runs four quarter-round lanes at half a
// quarter round per cycle and refills the next 64-byte block as the current one is consumed.
// A start_message byte waits at the queue head until its own block is generated, unless
// that block is already prefetched. After reset or a register write the generator refills
// at once, so a byte that needs that block waits only for its generation. After reset the
// stream begins at counter 0, byte 0, with all registers zero. A stalled receiver holds
// the output register; the four-entry input queue then fills and i_in.ready drops.
// Register writes must be made only while no byte is in flight; this is not enforced.
// A write drops any prefetched block, so new key and nonce apply from the next block.
`default_nettype none
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    cc20_in_if.sink                          i_in,
    cc20_out_if.source                       o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [cc20_pkg::ADDR_W-1:0] paddr,
    input  wire logic [cc20_pkg::DATA_W-1:0] pwdata,
    output logic      [cc20_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    logic [255:0]          key;
    logic [95:0]           nonce;
    logic [31:0]           init_ctr;
    logic                  cfg_wr;
    logic                  head_vld;
    cc20_pkg::t_item       head;
    logic                  pop;
    cc20_pkg::t_core_ctl   core_ctl;
    cc20_pkg::t_core_sts   core_sts;
    cc20_pkg::t_words      block;

    cc20_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_key      (key),
        .o_nonce    (nonce),
        .o_init_ctr (init_ctr),
        .o_wr       (cfg_wr)
    );

    cc20_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_head_vld (head_vld),
        .o_head     (head),
        .i_pop      (pop)
    );

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_key   (key),
        .i_nonce (nonce),
        .o_sts   (core_sts),
        .o_block (block)
    );

    cc20_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out),
        .i_cfg_wr   (cfg_wr),
        .i_init_ctr (init_ctr),
        .o_core_ctl (core_ctl),
        .i_core_sts (core_sts),
        .i_block    (block)
    );
endmodule
`default_nettype wire
